@@ src/stable_argsort_with_gap_check_core_macros.svh @@
// Assertion macros for the stable argsort core.
// Used by modules that carry concurrent checks; expects clk and rst_n in scope.
`ifndef STABLE_ARGSORT_WITH_GAP_CHECK_CORE_MACROS_SVH
`define STABLE_ARGSORT_WITH_GAP_CHECK_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SAGC_ASSERT_IMP(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define SAGC_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

@@ src/sagc_pkg.sv @@
// Shared types and constants for the stable argsort core.
// No dependencies; imported by the controller, datapath and top level.
`timescale 1ns / 1ps

package sagc_pkg;

  localparam int MAX_LEN = 64;
  localparam int ADDR_W  = $clog2(MAX_LEN);
  localparam int CNT_W   = $clog2(MAX_LEN + 1);
  localparam int VAL_W   = 32;
  localparam int POS_W   = 7;

  localparam logic [1:0] KIND_POS   = 2'd0;
  localparam logic [1:0] KIND_GAP   = 2'd1;
  localparam logic [1:0] KIND_SHORT = 2'd2;
  localparam logic [1:0] KIND_LONG  = 2'd3;

  typedef struct packed {
    logic [ADDR_W-1:0]       origin;
    logic signed [VAL_W-1:0] value;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // controller -> datapath
  typedef struct packed {
    logic load_in;
    logic ovf_set;
    logic ins_start;
    logic shift_step;
    logic place_hi;
    logic place_lo;
    logic idx_clr;
    logic scan_rd;
    logic scan_cmp;
    logic emit_pos;
    logic emit_gap;
    logic emit_err;
    logic list_clr;
  } sagc_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic count_full;
    logic count_zero;
    logic count_lt2;
    logic ovf;
    logic last;
    logic greater;
    logic j_zero;
    logic idx_last;
    logic eq;
    logic out_free;
  } sagc_sts_t;

endpackage

@@ src/sagc_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module sagc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ src/sagc_ctrl.sv @@
// Controller: sequences insertion, gap scan and result emission.
// Depends on sagc_pkg.
`timescale 1ns / 1ps

module sagc_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  sagc_pkg::sagc_sts_t sts,
  output sagc_pkg::sagc_cmd_t cmd
);
  import sagc_pkg::*;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_LOAD     = 4'd1;
  localparam logic [3:0] S_SHIFT    = 4'd2;
  localparam logic [3:0] S_PLACE0   = 4'd3;
  localparam logic [3:0] S_FIN      = 4'd4;
  localparam logic [3:0] S_ERR      = 4'd5;
  localparam logic [3:0] S_SCAN_RD  = 4'd6;
  localparam logic [3:0] S_SCAN_CMP = 4'd7;
  localparam logic [3:0] S_SCAN_END = 4'd8;
  localparam logic [3:0] S_GAP      = 4'd9;
  localparam logic [3:0] S_EMIT_RD  = 4'd10;
  localparam logic [3:0] S_EMIT_LD  = 4'd11;

  logic [3:0] state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_LOAD;
        end
      end
      S_LOAD: begin
        if (sts.count_full) begin
          cmd.ovf_set = 1'b1;
          state_nxt   = sts.last ? S_FIN : S_IDLE;
        end else if (sts.count_zero) begin
          cmd.place_lo = 1'b1;
          state_nxt    = sts.last ? S_FIN : S_IDLE;
        end else begin
          cmd.ins_start = 1'b1;
          state_nxt     = S_SHIFT;
        end
      end
      S_SHIFT: begin
        if (sts.greater) begin
          cmd.shift_step = 1'b1;
          if (sts.j_zero) begin
            state_nxt = S_PLACE0;
          end
        end else begin
          cmd.place_hi = 1'b1;
          state_nxt    = sts.last ? S_FIN : S_IDLE;
        end
      end
      S_PLACE0: begin
        cmd.place_lo = 1'b1;
        state_nxt    = sts.last ? S_FIN : S_IDLE;
      end
      S_FIN: begin
        if (sts.ovf || sts.count_lt2) begin
          state_nxt = S_ERR;
        end else begin
          cmd.idx_clr = 1'b1;
          state_nxt   = S_SCAN_RD;
        end
      end
      S_ERR: begin
        if (sts.out_free) begin
          cmd.emit_err = 1'b1;
          cmd.list_clr = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_SCAN_RD: begin
        cmd.scan_rd = 1'b1;
        state_nxt   = S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        cmd.scan_cmp = 1'b1;
        state_nxt    = sts.idx_last ? S_SCAN_END : S_SCAN_RD;
      end
      S_SCAN_END: begin
        cmd.idx_clr = 1'b1;
        state_nxt   = sts.eq ? S_EMIT_RD : S_GAP;
      end
      S_GAP: begin
        if (sts.out_free) begin
          cmd.emit_gap = 1'b1;
          cmd.list_clr = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_EMIT_RD: begin
        cmd.scan_rd = 1'b1;
        state_nxt   = S_EMIT_LD;
      end
      S_EMIT_LD: begin
        if (sts.out_free) begin
          cmd.emit_pos = 1'b1;
          if (sts.idx_last) begin
            cmd.list_clr = 1'b1;
            state_nxt    = S_IDLE;
          end else begin
            state_nxt = S_EMIT_RD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ src/sagc_dp.sv @@
// Datapath: sorted store, insertion pointer, gap scan registers, result register.
// Depends on sagc_pkg, sagc_ram and the assertion macro header.
`timescale 1ns / 1ps
`include "stable_argsort_with_gap_check_core_macros.svh"

module sagc_dp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic signed [31:0]          in_value,
  input  logic                        in_last,
  input  sagc_pkg::sagc_cmd_t         cmd,
  output sagc_pkg::sagc_sts_t         sts,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [1:0]                  out_kind,
  output logic [sagc_pkg::POS_W-1:0]  out_position,
  output logic [31:0]                 out_max_gap,
  output logic [31:0]                 out_min_gap,
  output logic                        out_end_of_run
);
  import sagc_pkg::*;

  logic signed [VAL_W-1:0] v_r;
  logic                    last_r;
  logic [CNT_W-1:0]        count_r;
  logic                    ovf_r;
  logic [ADDR_W-1:0]       j_r;
  logic [ADDR_W-1:0]       idx_r;
  logic signed [VAL_W-1:0] prev_r;
  logic [VAL_W-1:0]        first_r, mx_r, mn_r;
  logic                    eq_r;

  logic                    out_valid_r;
  logic [1:0]              out_kind_r;
  logic [POS_W-1:0]        out_position_r;
  logic [VAL_W-1:0]        out_max_gap_r, out_min_gap_r;
  logic                    out_end_r;

  logic                    ram_we, ram_re;
  logic [ADDR_W-1:0]       ram_waddr, ram_raddr;
  entry_t                  ram_wdata, rd_q;
  logic [ENTRY_W-1:0]      ram_rdata;

  logic [CNT_W-1:0]        count_m1;
  logic [ADDR_W-1:0]       j_p1;
  logic [VAL_W-1:0]        gap;
  logic                    out_free;

  assign rd_q     = entry_t'(ram_rdata);
  assign count_m1 = count_r - CNT_W'(1);
  assign j_p1     = j_r + ADDR_W'(1);
  assign gap      = VAL_W'(rd_q.value - prev_r);
  assign out_free = !out_valid_r || out_ready;

  // store port selection: only one write command is active in a cycle
  always_comb begin
    ram_we    = cmd.shift_step || cmd.place_hi || cmd.place_lo;
    ram_waddr = cmd.place_lo ? '0 : j_p1;
    if (cmd.shift_step) begin
      ram_wdata = rd_q;
    end else begin
      ram_wdata.origin = count_r[ADDR_W-1:0];
      ram_wdata.value  = v_r;
    end
    ram_re = cmd.ins_start || cmd.shift_step || cmd.scan_rd;
    if (cmd.ins_start) begin
      ram_raddr = count_m1[ADDR_W-1:0];
    end else if (cmd.shift_step) begin
      ram_raddr = j_r - ADDR_W'(1);
    end else begin
      ram_raddr = idx_r;
    end
  end

  sagc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_LEN)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    sts.count_full = (count_r == CNT_W'(MAX_LEN));
    sts.count_zero = (count_r == '0);
    sts.count_lt2  = (count_r < CNT_W'(2));
    sts.ovf        = ovf_r;
    sts.last       = last_r;
    sts.greater    = (rd_q.value > v_r);
    sts.j_zero     = (j_r == '0);
    sts.idx_last   = ({1'b0, idx_r} == count_m1);
    sts.eq         = eq_r;
    sts.out_free   = out_free;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.list_clr) begin
        count_r <= '0;
        ovf_r   <= 1'b0;
      end else begin
        if (cmd.place_hi || cmd.place_lo) begin
          count_r <= count_r + CNT_W'(1);
        end
        if (cmd.ovf_set) begin
          ovf_r <= 1'b1;
        end
      end
      if (cmd.emit_pos || cmd.emit_gap || cmd.emit_err) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      v_r    <= in_value;
      last_r <= in_last;
    end
    if (cmd.ins_start) begin
      j_r <= count_m1[ADDR_W-1:0];
    end else if (cmd.shift_step) begin
      j_r <= j_r - ADDR_W'(1);
    end
    if (cmd.idx_clr) begin
      idx_r <= '0;
    end else if (cmd.scan_cmp || cmd.emit_pos) begin
      idx_r <= idx_r + ADDR_W'(1);
    end
    if (cmd.scan_cmp) begin
      prev_r <= rd_q.value;
      if (idx_r == ADDR_W'(1)) begin
        first_r <= gap;
        mx_r    <= gap;
        mn_r    <= gap;
        eq_r    <= 1'b1;
      end else if (idx_r != '0) begin
        if (gap != first_r) begin
          eq_r <= 1'b0;
        end
        if (gap > mx_r) begin
          mx_r <= gap;
        end
        if (gap < mn_r) begin
          mn_r <= gap;
        end
      end
    end
    if (cmd.emit_pos) begin
      out_kind_r     <= KIND_POS;
      out_position_r <= POS_W'({1'b0, rd_q.origin}) + POS_W'(1);
      out_max_gap_r  <= '0;
      out_min_gap_r  <= '0;
      out_end_r      <= sts.idx_last;
    end else if (cmd.emit_gap) begin
      out_kind_r     <= KIND_GAP;
      out_position_r <= '0;
      out_max_gap_r  <= mx_r;
      out_min_gap_r  <= mn_r;
      out_end_r      <= 1'b1;
    end else if (cmd.emit_err) begin
      out_kind_r     <= ovf_r ? KIND_LONG : KIND_SHORT;
      out_position_r <= '0;
      out_max_gap_r  <= '0;
      out_min_gap_r  <= '0;
      out_end_r      <= 1'b1;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_kind       = out_kind_r;
  assign out_position   = out_position_r;
  assign out_max_gap    = out_max_gap_r;
  assign out_min_gap    = out_min_gap_r;
  assign out_end_of_run = out_end_r;

  `SAGC_ASSERT_IMP(a_count_range, 1'b1, count_r <= CNT_W'(MAX_LEN), "count beyond store depth")
  `SAGC_ASSERT_IMP(a_shift_greater, cmd.shift_step, sts.greater, "shift of a value not above new one")
  `SAGC_ASSERT_IMP(a_emit_free, cmd.emit_pos || cmd.emit_gap || cmd.emit_err, out_free, "result register overwritten")
  `SAGC_ASSERT_NEXT(a_place_grows, (cmd.place_hi || cmd.place_lo) && !cmd.list_clr, count_r != '0, "count did not grow on insert")

endmodule

@@ src/stable_argsort_with_gap_check_core.sv @@
// Stable argsort with gap check: one value per transaction, one insertion at a time.
// Insertion shifts stored entries above the new value up one and writes it below them; the
// store has one read and one write port. An empty store takes a value directly; a full one
// drops it and sets the overflow flag. After the last value: an error result if too long
// or short, else a gap scan and a gap result, or per-entry positions if gaps are equal.
// Reset clears count, overflow flag, result valid and state. Uses sagc_ctrl and sagc_dp.
`timescale 1ns / 1ps

module stable_argsort_with_gap_check_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [31:0]         in_value,
  input  logic                       in_last,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [1:0]                 out_kind,
  output logic [sagc_pkg::POS_W-1:0] out_position,
  output logic [31:0]                out_max_gap,
  output logic [31:0]                out_min_gap,
  output logic                       out_end_of_run
);
  import sagc_pkg::*;

  sagc_cmd_t cmd;
  sagc_sts_t sts;

  sagc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  sagc_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_value       (in_value),
    .in_last        (in_last),
    .cmd            (cmd),
    .sts            (sts),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_kind       (out_kind),
    .out_position   (out_position),
    .out_max_gap    (out_max_gap),
    .out_min_gap    (out_min_gap),
    .out_end_of_run (out_end_of_run)
  );

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps
// Testbench for stable_argsort_with_gap_check_core: streams lists of signed values and checks
// sorted arrival positions, gap pairs and length errors against an in-bench predictor.
// Depends on sagc_pkg and the core RTL.

module tb;
  import sagc_pkg::*;

  localparam int STALL_LIMIT = 4000;
  localparam int TAIL_CYCLES = 300;
  localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] VAL_MAX = 32'sh7FFF_FFFF;

  typedef struct {
    logic [1:0]       kind;
    logic [POS_W-1:0] position;
    logic [31:0]      max_gap;
    logic [31:0]      min_gap;
    logic             end_of_run;
  } sort_result_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [31:0] in_value = '0;
  logic               in_last = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [1:0]         out_kind;
  logic [POS_W-1:0]   out_position;
  logic [31:0]        out_max_gap;
  logic [31:0]        out_min_gap;
  logic               out_end_of_run;

  // predictor state
  sort_result_t expected_results[$];
  longint       sorted_vals[MAX_LEN];
  int           sorted_origin[MAX_LEN];
  int           stored_count = 0;
  bit           dropped_flag = 1'b0;

  int list_values[$];
  int error_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int quiet_cycles = 0;

  stable_argsort_with_gap_check_core dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_value       (in_value),
    .in_last        (in_last),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_kind       (out_kind),
    .out_position   (out_position),
    .out_max_gap    (out_max_gap),
    .out_min_gap    (out_min_gap),
    .out_end_of_run (out_end_of_run)
  );

  always #1 clk = ~clk;

  function automatic sort_result_t make_result(logic [1:0] kind, int pos, logic [31:0] mx,
                                               logic [31:0] mn, logic eor);
    sort_result_t r;
    r.kind       = kind;
    r.position   = POS_W'(pos);
    r.max_gap    = mx;
    r.min_gap    = mn;
    r.end_of_run = eor;
    return r;
  endfunction

  // Insert one value into the sorted copy; on the last value, queue the list's results.
  function automatic void predict_item(logic signed [31:0] v, logic last);
    int          j;
    logic [31:0] first_gap;
    logic [31:0] g;
    logic [31:0] mx;
    logic [31:0] mn;
    bit          all_equal;
    if (stored_count < MAX_LEN) begin
      j = stored_count;
      // move only strictly greater values so ties keep arrival order
      while (j > 0 && sorted_vals[j-1] > longint'(v)) begin
        sorted_vals[j]   = sorted_vals[j-1];
        sorted_origin[j] = sorted_origin[j-1];
        j--;
      end
      sorted_vals[j]   = longint'(v);
      sorted_origin[j] = stored_count;
      stored_count++;
    end else begin
      dropped_flag = 1'b1;
    end
    if (!last) return;
    if (dropped_flag) begin
      expected_results.push_back(make_result(KIND_LONG, 0, '0, '0, 1'b1));
    end else if (stored_count < 2) begin
      expected_results.push_back(make_result(KIND_SHORT, 0, '0, '0, 1'b1));
    end else begin
      first_gap = 32'(sorted_vals[1] - sorted_vals[0]);
      mx = first_gap;
      mn = first_gap;
      all_equal = 1'b1;
      for (int i = 2; i < stored_count; i++) begin
        g = 32'(sorted_vals[i] - sorted_vals[i-1]);
        if (g != first_gap) all_equal = 1'b0;
        if (g > mx) mx = g;
        if (g < mn) mn = g;
      end
      if (all_equal) begin
        for (int i = 0; i < stored_count; i++)
          expected_results.push_back(make_result(KIND_POS, sorted_origin[i] + 1, '0, '0,
                                                 i == stored_count - 1));
      end else begin
        expected_results.push_back(make_result(KIND_GAP, 0, mx, mn, 1'b1));
      end
    end
    stored_count = 0;
    dropped_flag = 1'b0;
  endfunction

  function automatic void report_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      error_count++;
    end
  endfunction

  task automatic check_result();
    sort_result_t want;
    if (expected_results.size() == 0) begin
      $display("%0t: unexpected result: expected none, actual kind %0d position %0d %0h %0h",
               $time, out_kind, out_position, out_max_gap, out_min_gap);
      error_count++;
      return;
    end
    want = expected_results.pop_front();
    report_field("kind", 32'(want.kind), 32'(out_kind));
    report_field("position", 32'(want.position), 32'(out_position));
    report_field("max_gap", want.max_gap, out_max_gap);
    report_field("min_gap", want.min_gap, out_min_gap);
    report_field("end_of_run", 32'(want.end_of_run), 32'(out_end_of_run));
  endtask

  // Result side: check each transaction, then pick next cycle's ready.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) check_result();
    out_ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
      $display("stable_argsort_with_gap_check_core verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_item(input logic signed [31:0] v, input logic last);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_value <= v;
    in_last  <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_item(v, last);
  endtask

  task automatic send_list();
    foreach (list_values[i]) send_item(list_values[i], i == list_values.size() - 1);
  endtask

  // Hold off the sender until every queued result has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  task automatic shuffle_list();
    int k;
    int tmp;
    for (int i = list_values.size() - 1; i > 0; i--) begin
      k = $urandom_range(i);
      tmp = list_values[i];
      list_values[i] = list_values[k];
      list_values[k] = tmp;
    end
  endtask

  // Shuffled arithmetic progression of n values that fits in 32 signed bits.
  task automatic build_progression(input int n);
    longint          step;
    longint          max_step;
    longint          span;
    longint          start;
    longint unsigned r;
    int              mode;
    list_values.delete();
    max_step = (n > 1) ? 64'sd4294967295 / (n - 1) : 64'sd0;
    mode = $urandom_range(5);
    r = {$urandom(), $urandom()};
    if (mode == 0) step = 0;
    else if (mode < 4) step = $urandom_range(1, 16);
    else step = longint'(r % unsigned'(max_step + 1));
    if (step > max_step) step = max_step;
    span = 64'sd4294967295 - step * (n - 1);
    r = {$urandom(), $urandom()};
    start = -64'sd2147483648 + longint'(r % unsigned'(span + 1));
    for (int i = 0; i < n; i++) list_values.push_back(int'(start + i * step));
    shuffle_list();
  endtask

  task automatic build_random_list(input int n);
    bit narrow;
    list_values.delete();
    narrow = $urandom_range(1);
    for (int i = 0; i < n; i++)
      list_values.push_back(narrow ? int'($urandom_range(0, 6)) - 3 : int'($urandom()));
  endtask

  task automatic test_short_lists();
    list_values = '{VAL_MIN};
    send_list();
    list_values = '{VAL_MAX};
    send_list();
  endtask

  task automatic test_extreme_pairs();
    list_values = '{VAL_MAX, VAL_MIN};
    send_list();
    list_values = '{VAL_MIN, VAL_MAX};
    send_list();
    // smallest gap sits at the top of the sorted list
    list_values = '{VAL_MAX, VAL_MIN, 0};
    send_list();
  endtask

  task automatic test_stable_ties();
    list_values = '{-1, -1, -1, -1};
    send_list();
    list_values = '{5, 3, 5, 3};
    send_list();
  endtask

  task automatic test_gap_pairs();
    list_values = '{0, 10, 13};
    send_list();
    list_values = '{100, -5, 5};
    send_list();
  endtask

  task automatic test_shuffled_progression();
    list_values = '{30, 10, 20, 0};
    send_list();
  endtask

  // Fill the store exactly, then overrun it with the last value being dropped.
  task automatic test_store_limits();
    build_progression(MAX_LEN);
    send_list();
    build_random_list(MAX_LEN + 1);
    send_list();
    list_values = '{7, -7};
    send_list();
    drain_results();
  endtask

  task automatic test_random_lists(input int idle_pct, input int stall_pct, input int n_items);
    int sent;
    int shape;
    int n;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    sent = 0;
    while (sent < n_items) begin
      shape = $urandom_range(99);
      n = ($urandom_range(7) == 0) ? $urandom_range(7, 20) : $urandom_range(2, 6);
      if (shape < 45) begin
        build_progression(n);
      end else if (shape < 60) begin
        build_progression(n < 3 ? 3 : n);
        list_values[$urandom_range(list_values.size() - 1)] = $urandom();
      end else if (shape < 90) begin
        build_random_list(n);
      end else begin
        build_random_list(1);
      end
      send_list();
      sent += list_values.size();
      if ($urandom_range(9) == 0) drain_results();
    end
    drain_results();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_short_lists();
    test_extreme_pairs();
    test_stable_ties();
    test_gap_pairs();
    test_shuffled_progression();
    drain_results();
    test_store_limits();
    test_random_lists(0, 0, 65);
    test_random_lists(85, 0, 65);
    test_random_lists(0, 85, 65);
    test_random_lists(38, 38, 65);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0 && expected_results.size() == 0)
      $display("stable_argsort_with_gap_check_core verification clean");
    else
      $display("stable_argsort_with_gap_check_core verification failed");
    $finish;
  end

endmodule
